[rtl/core/pbra_pkg.sv]
// Shared constants, codes and types for the page bitmap run allocator.
package pbra_pkg;

	localparam int MAX_PAGES_DEF = 4096;
	localparam int WORD_W        = 8;
	localparam int WORD_B        = 3;
	localparam int PGW           = 14;
	localparam int CNT_W         = 13;
	localparam int START_W       = 12;
	localparam int OP_W          = 2;
	localparam int IN_W          = 32;
	localparam int OUT_W         = 32;
	localparam int COUNT_MAX     = 8191;

	localparam logic [OP_W-1:0] OP_ALLOC_FIRST = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC_NEXT  = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE        = 2'd2;
	localparam logic [OP_W-1:0] OP_RESERVE     = 2'd3;

	typedef struct packed {
		logic [PGW-1:0] run;
		logic [PGW-1:0] head;
	} scan_st_t;

	typedef struct packed {
		scan_st_t       st;
		logic           hit;
		logic [PGW-1:0] first;
	} scan_res_t;

endpackage

[rtl/core/pbra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pbra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/pbra_scan.sv]
// Run scan unit: advances the free-run tracker across one bitmap word.
module pbra_scan (
	input  logic [pbra_pkg::WORD_W-1:0] word,
	input  logic [pbra_pkg::PGW-1:0]    base,
	input  logic [pbra_pkg::PGW-1:0]    from,
	input  logic [pbra_pkg::PGW-1:0]    limit,
	input  logic [pbra_pkg::PGW-1:0]    len,
	input  pbra_pkg::scan_st_t          st_in,
	output pbra_pkg::scan_res_t         res
);
	import pbra_pkg::*;

	always_comb begin
		logic [PGW-1:0] p;
		logic [PGW-1:0] run;
		logic [PGW-1:0] head;
		logic           hit;
		logic [PGW-1:0] first;
		run   = st_in.run;
		head  = st_in.head;
		hit   = 1'b0;
		first = '0;
		for (int j = 0; j < WORD_W; j++) begin
			p = base + PGW'(j);
			if (!hit && p >= from && p < limit) begin
				if (!word[j]) begin
					if (run == '0) begin
						head = p;
					end
					run = run + 1'b1;
					if (run == len) begin
						hit   = 1'b1;
						first = head;
					end
				end else begin
					run = '0;
				end
			end
		end
		res.st.run  = run;
		res.st.head = head;
		res.hit     = hit;
		res.first   = first;
	end

endmodule

[rtl/core/page_bitmap_run_allocator.sv]
// Top level of the page bitmap run allocator: sequencer, bitmap RAM and scan unit.
//
// Usage: one request transfer on the s_ channel gives exactly one result transfer
// on the m_ channel. Requests carry an opcode (first-fit alloc, next-fit alloc,
// free, reserve), a start page and a page count. Results carry the found page,
// an ok flag and the used page count. cfg_we/cfg_wdata set the managed page
// count; write it only while no request is in flight.
// The bitmap sits in a RAM of 8-page words. After reset a clearing pass marks
// every page used, with s_tready low. Allocation scans one word per cycle from
// its start word (the hint for next-fit); a failed next-fit pass goes back
// through the read state and rescans from page 0.
// Marking the run then reads, modifies and writes each word touched.
// Free and reserve do the same over each word of their range.
// One request is in work at a time; s_tready is high only when idle. The
// result sits in an output register, so a new request is taken while it waits;
// a stalled m_tready holds the next result in the block.
module page_bitmap_run_allocator #(
	parameter int MAX_PAGES = pbra_pkg::MAX_PAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pbra_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// opcode[1:0], start_page[13:2], page_count[26:14], zero fill
	input  logic [pbra_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// found_page[11:0], ok[12], used_pages[25:13], zero fill
	output logic [pbra_pkg::OUT_W-1:0]  m_tdata
);
	import pbra_pkg::*;

	localparam int WORDS     = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MAXP_CLIP = (MAX_PAGES > COUNT_MAX) ? COUNT_MAX : MAX_PAGES;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SRD  = 3'd2;
	localparam logic [2:0] ST_SEV  = 3'd3;
	localparam logic [2:0] ST_FRD  = 3'd4;
	localparam logic [2:0] ST_FWR  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   managed_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      word_q;
	logic [AW-1:0]      fw_q;
	logic [PGW-1:0]     limit_q;
	logic [PGW-1:0]     len_q;
	logic [PGW-1:0]     from_q;
	logic [PGW-1:0]     fs_q;
	logic [PGW-1:0]     fend_q;
	logic               fv_q;
	logic               nf_q;
	logic [CNT_W-1:0]   hint_q;
	logic [CNT_W-1:0]   used_q;
	logic [START_W-1:0] found_q;
	logic               ok_q;
	scan_st_t           st_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [OP_W-1:0]    in_op;
	logic [PGW-1:0]     in_start;
	logic [PGW-1:0]     in_len;
	logic [PGW-1:0]     lim;
	logic [PGW-1:0]     in_end;
	logic [PGW-1:0]     hint_ext;
	logic [PGW-1:0]     used_ext;
	logic [PGW-1:0]     used_add;
	logic [PGW-1:0]     word_base;
	logic [PGW-1:0]     fill_base;
	logic               scan_last;
	logic               fill_last;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic [WORD_W-1:0]  fill_word;
	scan_res_t          scan_res;

	assign in_op    = s_tdata[1:0];
	assign in_start = PGW'(s_tdata[13:2]);
	assign in_len   = PGW'(s_tdata[26:14]);
	assign lim      = (PGW'(managed_q) > PGW'(MAXP_CLIP)) ? PGW'(MAXP_CLIP) : PGW'(managed_q);
	assign in_end   = ((in_start + in_len) > lim) ? lim : (in_start + in_len);
	assign hint_ext = PGW'(hint_q);
	assign used_ext = PGW'(used_q);
	assign used_add = used_ext + len_q;

	assign word_base = PGW'({word_q, {WORD_B{1'b0}}});
	assign fill_base = PGW'({fw_q, {WORD_B{1'b0}}});
	assign scan_last = ({1'b0, word_base} + (PGW+1)'(WORD_W)) >= {1'b0, limit_q};
	assign fill_last = ({1'b0, fill_base} + (PGW+1)'(WORD_W)) >= {1'b0, fend_q};

	pbra_scan u_scan (
		.word  (ram_rdata),
		.base  (word_base),
		.from  (from_q),
		.limit (limit_q),
		.len   (len_q),
		.st_in (st_q),
		.res   (scan_res)
	);

	always_comb begin
		logic [PGW-1:0] p;
		for (int j = 0; j < WORD_W; j++) begin
			p = fill_base + PGW'(j);
			fill_word[j] = (p >= fs_q && p < fend_q) ? fv_q : ram_rdata[j];
		end
	end

	always_comb begin
		unique case (state_q)
			ST_SEV:  ram_raddr = AW'(word_q + 1'b1);
			ST_FRD:  ram_raddr = fw_q;
			default: ram_raddr = word_q;
		endcase
	end

	assign ram_we    = (state_q == ST_INIT) || (state_q == ST_FWR);
	assign ram_waddr = (state_q == ST_INIT) ? clr_q : fw_q;
	assign ram_wdata = (state_q == ST_INIT) ? {WORD_W{1'b1}} : fill_word;

	pbra_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= CNT_W'(4096);
		end else if (cfg_we) begin
			managed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			clr_q      <= '0;
			hint_q     <= '0;
			used_q     <= '0;
			nf_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == AW'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						limit_q <= lim;
						len_q   <= in_len;
						st_q    <= '0;
						found_q <= '0;
						unique case (in_op)
							OP_ALLOC_FIRST, OP_ALLOC_NEXT: begin
								if (in_len == '0 || in_len > lim) begin
									ok_q    <= 1'b0;
									state_q <= ST_DONE;
									if (in_op == OP_ALLOC_NEXT) begin
										hint_q <= '0;
									end
								end else begin
									state_q <= ST_SRD;
									if (in_op == OP_ALLOC_NEXT && hint_ext < lim) begin
										nf_q   <= 1'b1;
										from_q <= hint_ext;
										word_q <= AW'(hint_ext >> WORD_B);
									end else begin
										nf_q   <= 1'b0;
										from_q <= '0;
										word_q <= '0;
										if (in_op == OP_ALLOC_NEXT) begin
											hint_q <= '0;
										end
									end
								end
							end
							OP_FREE, OP_RESERVE: begin
								ok_q <= 1'b1;
								fv_q <= (in_op == OP_RESERVE);
								if (in_op == OP_FREE) begin
									used_q <= (used_ext > in_len) ? CNT_W'(used_ext - in_len) : '0;
								end
								fs_q   <= in_start;
								fend_q <= in_end;
								fw_q   <= AW'(in_start >> WORD_B);
								state_q <= (in_start >= lim) ? ST_DONE : ST_FRD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SRD: begin
					state_q <= ST_SEV;
				end
				ST_SEV: begin
					if (scan_res.hit) begin
						ok_q    <= 1'b1;
						found_q <= START_W'(scan_res.first);
						if (nf_q) begin
							hint_q <= CNT_W'(scan_res.first + len_q);
						end
						used_q  <= (used_add > PGW'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
						                                       : CNT_W'(used_add);
						fv_q    <= 1'b1;
						fs_q    <= scan_res.first;
						fend_q  <= scan_res.first + len_q;
						fw_q    <= AW'(scan_res.first >> WORD_B);
						state_q <= ST_FRD;
					end else if (scan_last) begin
						if (nf_q) begin
							nf_q    <= 1'b0;
							hint_q  <= '0;
							from_q  <= '0;
							word_q  <= '0;
							st_q    <= '0;
							state_q <= ST_SRD;
						end else begin
							ok_q    <= 1'b0;
							state_q <= ST_DONE;
						end
					end else begin
						st_q   <= scan_res.st;
						word_q <= AW'(word_q + 1'b1);
					end
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					if (fill_last) begin
						state_q <= ST_DONE;
					end else begin
						fw_q    <= AW'(fw_q + 1'b1);
						state_q <= ST_FRD;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {(OUT_W - START_W - 1 - CNT_W)'(0), used_q, ok_q, found_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/pbra_checker.sv]
// Port-level checks for the page bitmap run allocator, bound to the top level.
module pbra_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [pbra_pkg::OUT_W-1:0] m_tdata
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_fail_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[12]) |-> (m_tdata[11:0] == 12'd0))
		else $error("failed allocation reports a page");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without work in progress");

endmodule

bind page_bitmap_run_allocator pbra_checker u_pbra_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the page bitmap run allocator with a built-in predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pbra_pkg::*;

	localparam int PAGES        = 4096;
	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int DRAIN_CYCLES = 2100;

	typedef struct {
		logic [START_W-1:0] found_page;
		logic               ok;
		logic [CNT_W-1:0]   used_pages;
	} page_res_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	// opcode[1:0], start_page[13:2], page_count[26:14], zero fill
	logic [IN_W-1:0]    s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	// found_page[11:0], ok[12], used_pages[25:13], zero fill
	logic [OUT_W-1:0]   m_tdata;

	logic [IN_W-1:0]    req_q[$];
	page_res_t          outcome_q[$];
	logic               s_taken      = 1'b0;
	int                 send_idle    = 25;
	int                 recv_idle    = 78;
	int                 issued_cnt   = 0;
	int                 accepted_cnt = 0;
	int                 err_cnt      = 0;
	int unsigned        cycle_cnt    = 0;

	bit                 page_map [PAGES];
	logic [CNT_W-1:0]   next_hint  = '0;
	logic [CNT_W-1:0]   used_count = '0;
	logic [CNT_W-1:0]   managed    = 13'd4096;

	page_bitmap_run_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit seek_free_run(int from, int lim, int len, output int head);
		int run = 0;
		head = 0;
		if (len == 0 || len > lim)
			return 1'b0;
		for (int p = from; p < lim; p++) begin
			if (!page_map[p]) begin
				if (run == 0)
					head = p;
				run++;
				if (run == len)
					return 1'b1;
			end else begin
				run = 0;
			end
		end
		return 1'b0;
	endfunction

	function automatic void mark_range(int start, int len, bit v, int lim);
		for (int i = 0; i < len; i++) begin
			if (start + i >= lim)
				break;
			page_map[start + i] = v;
		end
	endfunction

	function automatic page_res_t apply_request(logic [OP_W-1:0] opcode, int start, int len);
		page_res_t res;
		int lim;
		int head;
		int total;
		bit hit;
		lim = (managed > PAGES) ? PAGES : int'(managed);
		head = 0;
		hit = 1'b0;
		res.found_page = '0;
		res.ok = 1'b1;
		case (opcode)
		OP_ALLOC_FIRST, OP_ALLOC_NEXT: begin
			if (opcode == OP_ALLOC_NEXT) begin
				if (seek_free_run(int'(next_hint), lim, len, head)) begin
					hit = 1'b1;
					next_hint = CNT_W'(head + len);
				end else begin
					next_hint = '0;
				end
			end
			if (!hit)
				hit = seek_free_run(0, lim, len, head);
			if (hit) begin
				mark_range(head, len, 1'b1, lim);
				total = int'(used_count) + len;
				used_count = (total > COUNT_MAX) ? CNT_W'(COUNT_MAX) : CNT_W'(total);
				res.found_page = START_W'(head);
			end else begin
				res.ok = 1'b0;
			end
		end
		OP_FREE: begin
			mark_range(start, len, 1'b0, lim);
			used_count = (int'(used_count) > len) ? CNT_W'(int'(used_count) - len) : '0;
		end
		default: begin
			mark_range(start, len, 1'b1, lim);
		end
		endcase
		res.used_pages = used_count;
		return res;
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				s_tdata  <= req_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin : result_check
		page_res_t want;
		page_res_t got;
		if (arst_n) begin
			if (cfg_we)
				managed = cfg_wdata;
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_request(s_tdata[1:0], int'(s_tdata[13:2]),
					int'(s_tdata[26:14])));
				accepted_cnt++;
			end
			if (m_tvalid && m_tready) begin
				got.found_page = m_tdata[11:0];
				got.ok         = m_tdata[12];
				got.used_pages = m_tdata[25:13];
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result found_page %0d ok %0d used_pages %0d",
						$time, got.found_page, got.ok, got.used_pages);
					err_cnt++;
				end else begin
					want = outcome_q.pop_front();
					if (got.found_page !== want.found_page) begin
						$display("%0t: found_page expected %0d actual %0d",
							$time, want.found_page, got.found_page);
						err_cnt++;
					end
					if (got.ok !== want.ok) begin
						$display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
						err_cnt++;
					end
					if (got.used_pages !== want.used_pages) begin
						$display("%0t: used_pages expected %0d actual %0d",
							$time, want.used_pages, got.used_pages);
						err_cnt++;
					end
				end
			end
		end
		s_taken <= arst_n && s_tvalid && s_tready;
	end

	task automatic add_req(logic [OP_W-1:0] opcode, int start, int count);
		req_q.push_back(IN_W'({CNT_W'(count), START_W'(start), opcode}));
		issued_cnt++;
	endtask

	task automatic drain();
		@(negedge clk);
		while (accepted_cnt != issued_cnt || outcome_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_pages(int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_random(int lim, int span);
		int r;
		int count;
		int start;
		logic [OP_W-1:0] opcode;
		r = $urandom_range(99);
		opcode = (r < 30) ? OP_ALLOC_FIRST : (r < 60) ? OP_ALLOC_NEXT :
			(r < 85) ? OP_FREE : OP_RESERVE;
		r = $urandom_range(99);
		if (r < 3)
			count = 0;
		else if (r < 6)
			count = $urandom_range(8191);
		else if (r < 9)
			count = lim;
		else
			count = 1 + $urandom_range(span - 1);
		if ($urandom_range(99) < 12)
			start = $urandom_range(4095);
		else
			start = $urandom_range(lim - 1);
		add_req(opcode, start, count);
	endtask

	task automatic random_phase(int pages_cfg, int n, int span, int s_idle, int r_idle);
		int lim;
		write_pages(pages_cfg);
		send_idle = s_idle;
		recv_idle = r_idle;
		lim = (pages_cfg > PAGES) ? PAGES : pages_cfg;
		add_req(OP_FREE, 0, lim);
		repeat (n)
			add_random(lim, span);
	endtask

	initial begin
		foreach (page_map[i])
			page_map[i] = 1'b1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_req(OP_ALLOC_FIRST, 0, 1);
		add_req(OP_ALLOC_NEXT, 0, 1);
		add_req(OP_FREE, 4095, 1);
		add_req(OP_ALLOC_FIRST, 0, 0);
		add_req(OP_ALLOC_NEXT, 0, 1);
		add_req(OP_FREE, 0, 8191);
		add_req(OP_ALLOC_NEXT, 0, 2);
		add_req(OP_ALLOC_FIRST, 0, 8191);
		add_req(OP_ALLOC_FIRST, 0, 4094);
		add_req(OP_FREE, 100, 50);
		add_req(OP_ALLOC_NEXT, 0, 60);
		add_req(OP_ALLOC_NEXT, 0, 20);
		add_req(OP_ALLOC_NEXT, 0, 20);
		add_req(OP_ALLOC_NEXT, 0, 20);
		add_req(OP_ALLOC_FIRST, 0, 10);
		add_req(OP_RESERVE, 4000, 4096);
		add_req(OP_FREE, 2730, 1365);
		add_req(OP_RESERVE, 1365, 2730);
		add_req(OP_ALLOC_FIRST, 0, 4096);

		write_pages(0);
		add_req(OP_ALLOC_FIRST, 0, 1);
		add_req(OP_FREE, 0, 4096);
		add_req(OP_ALLOC_NEXT, 0, 1);

		write_pages(1);
		add_req(OP_FREE, 0, 1);
		add_req(OP_ALLOC_NEXT, 0, 1);
		add_req(OP_ALLOC_NEXT, 0, 1);
		add_req(OP_FREE, 0, 4096);
		add_req(OP_ALLOC_NEXT, 0, 1);
		add_req(OP_ALLOC_FIRST, 0, 2);

		random_phase(64, 250, 16, 25, 78);
		random_phase(1000, 150, 64, 25, 78);
		random_phase(200, 250, 32, 78, 25);
		random_phase(8191, 100, 64, 78, 25);
		random_phase(37, 150, 8, 0, 0);

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_cnt == 0 && outcome_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/pbra_pkg.sv
rtl/core/pbra_ram.sv
rtl/core/pbra_scan.sv
rtl/core/page_bitmap_run_allocator.sv
rtl/core/pbra_checker.sv
verif/testbench.sv
